FILE: rtl/kdpc_pkg.sv
// Package for the key debounce and press classifier.
// Holds the request and response structs, register indexes and reset values.
// It has no dependencies.
package kdpc_pkg;

  localparam int unsigned NumKeysDef = 4;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned KeysW   = 4;
  localparam int unsigned EventsW = 9;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MkeyW   = 2;

  localparam logic [CfgW-1:0]  ScanPeriodRst = 16'd10;
  localparam logic [CfgW-1:0]  DebounceRst   = 16'd25;
  localparam logic [CfgW-1:0]  ShortMinRst   = 16'd20;
  localparam logic [CfgW-1:0]  LongRst       = 16'd1000;
  localparam logic [CfgW-1:0]  MaintRst      = 16'd3000;
  localparam logic [KeysW-1:0] HoldMaskRst   = 4'd3;
  localparam logic [MkeyW-1:0] MaintKeyRst   = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScanPeriod = 3'd0,
    CfgDebounce   = 3'd1,
    CfgShortMin   = 3'd2,
    CfgLong       = 3'd3,
    CfgMaint      = 3'd4,
    CfgHoldMask   = 3'd5,
    CfgMaintKey   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [KeysW-1:0] raw_keys;
    logic             fetch_events;
  } in_req_t;

  typedef struct packed {
    logic [EventsW-1:0] events;
    logic [KeysW-1:0]   stable_keys;
  } out_rsp_t;

endpackage

FILE: rtl/key_debounce_press_classifier.sv
// Key debounce and press classifier: top level, depends on kdpc_pkg.
// A request passes two register stages, the input register and the result register.
// Throughput is one request per cycle when the output is not stalled; the per-key
// scan logic between the input and result registers updates all key state at once.
// Reset clears the handshake, the key state and the event bitmap, and loads
// the registers with their default values.
module key_debounce_press_classifier #(
  parameter int unsigned NUM_KEYS = kdpc_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kdpc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kdpc_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kdpc_pkg::out_rsp_t            out_rsp_o
);
  import kdpc_pkg::*;

  localparam int unsigned EvW     = 2 * NUM_KEYS + 1;
  localparam int unsigned EvExtW  = (EvW > EventsW) ? EvW : EventsW;
  localparam int unsigned KeyExtW = (NUM_KEYS > KeysW) ? NUM_KEYS : KeysW;

  logic [CfgW-1:0]  scan_period_q, debounce_q, short_min_q, long_q, maint_ms_q;
  logic [KeysW-1:0] hold_mask_q;
  logic [MkeyW-1:0] maint_key_q;

  logic     in_valid_q, out_valid_q;
  in_req_t  in_q;
  out_rsp_t out_q, out_d;
  logic     advance, fire;

  logic                seeded_q, seeded_d;
  logic [TimeW-1:0]    last_scan_q, last_scan_d;
  logic [EvW-1:0]      ev_q, ev_d, ev_scan;
  logic [NUM_KEYS-1:0] stable_q, stable_d, cand_q, cand_d;
  logic [NUM_KEYS-1:0] long_done_q, long_done_d, maint_done_q, maint_done_d;
  logic [TimeW-1:0]    since_q [NUM_KEYS];
  logic [TimeW-1:0]    since_d [NUM_KEYS];
  logic [TimeW-1:0]    press_q [NUM_KEYS];
  logic [TimeW-1:0]    press_d [NUM_KEYS];

  logic [KeyExtW-1:0]  raw_ext, mask_ext, stable_ext;
  logic [NUM_KEYS-1:0] raw_k, mask_k;
  logic [EvExtW-1:0]   ev_out_ext;
  logic                scan_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q <= ScanPeriodRst;
      debounce_q    <= DebounceRst;
      short_min_q   <= ShortMinRst;
      long_q        <= LongRst;
      maint_ms_q    <= MaintRst;
      hold_mask_q   <= HoldMaskRst;
      maint_key_q   <= MaintKeyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgScanPeriod: scan_period_q <= cfg_wdata_i;
        CfgDebounce:   debounce_q    <= cfg_wdata_i;
        CfgShortMin:   short_min_q   <= cfg_wdata_i;
        CfgLong:       long_q        <= cfg_wdata_i;
        CfgMaint:      maint_ms_q    <= cfg_wdata_i;
        CfgHoldMask:   hold_mask_q   <= cfg_wdata_i[KeysW-1:0];
        CfgMaintKey:   maint_key_q   <= cfg_wdata_i[MkeyW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign raw_ext  = KeyExtW'(in_q.raw_keys);
  assign mask_ext = KeyExtW'(hold_mask_q);
  assign raw_k    = raw_ext[NUM_KEYS-1:0];
  assign mask_k   = mask_ext[NUM_KEYS-1:0];
  assign scan_due = (in_q.now_ms - last_scan_q) >= TimeW'(scan_period_q);

  always_comb begin : scan_logic
    logic [TimeW-1:0] held;
    seeded_d     = seeded_q;
    last_scan_d  = last_scan_q;
    ev_scan      = ev_q;
    stable_d     = stable_q;
    cand_d       = cand_q;
    long_done_d  = long_done_q;
    maint_done_d = maint_done_q;
    held         = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      since_d[k] = since_q[k];
      press_d[k] = press_q[k];
    end
    if (!seeded_q) begin
      seeded_d     = 1'b1;
      last_scan_d  = '0;
      ev_scan      = '0;
      stable_d     = raw_k;
      cand_d       = raw_k;
      long_done_d  = '0;
      maint_done_d = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        since_d[k] = '0;
        press_d[k] = '0;
      end
    end else if (scan_due) begin
      last_scan_d = in_q.now_ms;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if ((raw_k[k] == stable_q[k]) || (raw_k[k] != cand_q[k])) begin
          cand_d[k]  = raw_k[k];
          since_d[k] = in_q.now_ms;
        end else if ((in_q.now_ms - since_q[k]) >= TimeW'(debounce_q)) begin
          stable_d[k] = raw_k[k];
          if (raw_k[k]) begin
            press_d[k]      = in_q.now_ms;
            long_done_d[k]  = 1'b0;
            maint_done_d[k] = 1'b0;
          end else if (!maint_done_q[k] && !long_done_q[k]) begin
            held = in_q.now_ms - press_q[k];
            if (held >= TimeW'(long_q)) begin
              ev_scan[NUM_KEYS + k] = 1'b1;
            end else if (held >= TimeW'(short_min_q)) begin
              ev_scan[k] = 1'b1;
            end
          end
        end
        held = in_q.now_ms - press_d[k];
        if (stable_d[k] && !long_done_d[k] && mask_k[k] && (held >= TimeW'(long_q))) begin
          ev_scan[NUM_KEYS + k] = 1'b1;
          long_done_d[k]        = 1'b1;
        end
        if ((int'(maint_key_q) == k) && stable_d[k] && !maint_done_d[k] &&
            (held >= TimeW'(maint_ms_q))) begin
          ev_scan[2 * NUM_KEYS] = 1'b1;
          maint_done_d[k]       = 1'b1;
        end
      end
    end
    ev_d = in_q.fetch_events ? '0 : ev_scan;
  end

  assign ev_out_ext        = in_q.fetch_events ? EvExtW'(ev_scan) : '0;
  assign stable_ext        = KeyExtW'(stable_d);
  assign out_d.events      = ev_out_ext[EventsW-1:0];
  assign out_d.stable_keys = stable_ext[KeysW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q     <= 1'b0;
      last_scan_q  <= '0;
      ev_q         <= '0;
      stable_q     <= '0;
      cand_q       <= '0;
      long_done_q  <= '0;
      maint_done_q <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        since_q[k] <= '0;
        press_q[k] <= '0;
      end
    end else if (fire) begin
      seeded_q     <= seeded_d;
      last_scan_q  <= last_scan_d;
      ev_q         <= ev_d;
      stable_q     <= stable_d;
      cand_q       <= cand_d;
      long_done_q  <= long_done_d;
      maint_done_q <= maint_done_d;
      for (int k = 0; k < NUM_KEYS; k++) begin
        since_q[k] <= since_d[k];
        press_q[k] <= press_d[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: rtl/kdpc_checker.sv
// Port-level checker for the key debounce and press classifier.
// Depends on kdpc_pkg and is attached to the top level by the bind below.
module kdpc_checker #(
  parameter int unsigned NUM_KEYS = kdpc_pkg::NumKeysDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input kdpc_pkg::in_req_t  in_req_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input kdpc_pkg::out_rsp_t out_rsp_i
);
  import kdpc_pkg::*;

  // A held result must not change until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rsp_i))
    else $error("result changed while stalled");

  // A waiting request keeps its contents until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while stalled");

  // The input side only stalls when a result is waiting and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // An accepted request reaches the output, through the input register, when nothing stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("request did not produce a result");

  // Keys beyond the configured count never show as pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((32'(out_rsp_i.stable_keys) >> NUM_KEYS) == 32'd0))
    else $error("unused key reported as pressed");

endmodule

bind key_debounce_press_classifier kdpc_checker #(
  .NUM_KEYS(NUM_KEYS)
) u_kdpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_i  (out_rsp_o)
);
